// File: rtl/core/plo_pkg.sv
package plo_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ADDR_W    = SLOT_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [2:0] REQ_CLAIM   = 3'd0;
    localparam logic [2:0] REQ_UPDATE  = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_TICK    = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_INVALID   = 2'd2;

    typedef struct packed {
        logic [7:0]  source;
        logic [7:0]  priority_val;
        logic [63:0] stamp;
        logic [63:0] expiry;
        logic [31:0] payload;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_START, S_SCAN, S_COMMIT, S_ONE, S_EVAL, S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_clr;
        logic scan_step;
        logic scan_dom;
        logic commit;
        logic load_one;
        logic load_win;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       dom;
        logic       scan_done;
        logic       out_busy;
    } stat_t;

endpackage

// File: rtl/core/priority_lease_owner_arbiter_core.sv
// Keeps two lease tables (expression, scene) and arbitrates ownership by priority, then
// newest claim. One request is handled at a time. A claim or update scans the SLOTS entries
// of its table once through a RAM read port, one entry a cycle; a release or a tick scans
// both tables in turn, and a clear or a bad request type scans none. A tick gives two items
// (one per domain), and its second pass starts only once the first item has been taken.
// A result waits in the output register until taken, and no new request is accepted before.
module priority_lease_owner_arbiter_core
    import plo_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // domain, domain_mask, source_id, priority_req, lease_len, payload, elapsed_ms
    input  logic [103:0] s_tdata,
    // req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_domain, winner_valid, winner_changed, winner_source, winner_priority,
    // winner_payload, lease_remaining
    output logic [87:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    plo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plo_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/core/plo_ram.sv
module plo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/plo_ctrl.sv
module plo_ctrl
    import plo_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.kind == REQ_CLAIM || stat.kind == REQ_UPDATE) begin
                    pass_next  = stat.dom;
                    state_next = S_START;
                end else if (stat.kind == REQ_RELEASE || stat.kind == REQ_TICK) begin
                    pass_next  = 1'b0;
                    state_next = S_START;
                end else begin
                    state_next = S_ONE;
                end
            end
            S_START: state_next = S_SCAN;
            S_SCAN: begin
                if (stat.scan_done) begin
                    if (stat.kind == REQ_CLAIM || stat.kind == REQ_UPDATE) begin
                        state_next = S_COMMIT;
                    end else if (stat.kind == REQ_TICK) begin
                        state_next = S_EVAL;
                    end else if (!pass_reg) begin
                        pass_next  = 1'b1;
                        state_next = S_START;
                    end else begin
                        state_next = S_ONE;
                    end
                end
            end
            S_COMMIT: state_next = S_OUT;
            S_ONE:    state_next = S_OUT;
            S_EVAL:   state_next = S_OUT;
            S_OUT: begin
                if (!stat.out_busy) begin
                    if (stat.kind == REQ_TICK && !pass_reg) begin
                        pass_next  = 1'b1;
                        state_next = S_START;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        cmd.accept    = (state_reg == S_IDLE) && s_tvalid;
        cmd.scan_clr  = (state_reg == S_START);
        cmd.scan_step = (state_reg == S_SCAN);
        cmd.scan_dom  = pass_reg;
        cmd.commit    = (state_reg == S_COMMIT);
        cmd.load_one  = (state_reg == S_COMMIT) || (state_reg == S_ONE);
        cmd.load_win  = (state_reg == S_EVAL);
    end

endmodule

// File: rtl/core/plo_dp.sv
module plo_dp
    import plo_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  logic [103:0] s_tdata,
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic [2:0]  type_reg;
    logic        dom_reg;
    logic [1:0]  mask_reg;
    logic [7:0]  src_reg, pri_reg;
    logic [31:0] lease_reg, pay_reg;
    logic [63:0] time_reg, stamp_reg;

    logic [RAM_DEPTH-1:0] valid_reg, valid_next;
    logic [1:0]           own_has_reg, own_has_next;
    logic [SLOT_W-1:0]    own_idx_reg [2];
    logic [SLOT_W-1:0]    own_idx_next [2];
    logic [1:0]           stale_reg, stale_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic              pv_reg;
    logic [SLOT_W-1:0] pslot_reg;

    logic              match_found_reg;
    logic [SLOT_W-1:0] match_idx_reg, oldest_idx_reg;
    logic [63:0]       oldest_stamp_reg;
    logic              win_found_reg;
    logic [SLOT_W-1:0] win_idx_reg;
    logic [7:0]        win_src_reg, win_pri_reg;
    logic [31:0]       win_pay_reg;
    logic [63:0]       win_exp_reg, win_stamp_reg;

    logic        out_valid_reg, out_last_reg, out_dom_reg, out_wv_reg, out_chg_reg;
    logic [1:0]  out_sts_reg;
    logic [7:0]  out_src_reg, out_pri_reg;
    logic [31:0] out_pay_reg, out_rem_reg;

    entry_t            rd_entry, wr_entry;
    logic [ADDR_W-1:0] raddr, waddr, paddr;
    logic              do_write;

    logic              pv_live, hit, expired, live, better;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx, cslot;
    logic [63:0]       new_stamp, new_exp, diff;
    logic [31:0]       rem;
    logic              changed;
    logic [1:0]        sts_v;

    plo_ram #(.WIDTH($bits(entry_t)), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    assign raddr = {cmd.scan_dom, cnt_reg[SLOT_W-1:0]};
    assign paddr = {cmd.scan_dom, pslot_reg};

    always_comb begin
        pv_live = cmd.scan_step && pv_reg;
        hit     = valid_reg[paddr] && (rd_entry.source == src_reg);
        expired = valid_reg[paddr] && (rd_entry.expiry != 64'd0)
                  && (rd_entry.expiry <= time_reg);
        live    = valid_reg[paddr] && !expired;
        better  = !win_found_reg || (rd_entry.priority_val > win_pri_reg)
                  || ((rd_entry.priority_val == win_pri_reg)
                      && (rd_entry.stamp > win_stamp_reg));
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[{dom_reg, SLOT_W'(i)}]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        cslot = match_found_reg ? match_idx_reg : (free_found ? free_idx : oldest_idx_reg);
        do_write  = cmd.commit && (type_reg == REQ_CLAIM || match_found_reg);
        waddr     = {dom_reg, cslot};
        new_stamp = stamp_reg + 64'd1;
        new_exp   = (lease_reg == 32'd0) ? 64'd0 : time_reg + {32'd0, lease_reg};
        wr_entry.source       = src_reg;
        wr_entry.priority_val = pri_reg;
        wr_entry.stamp        = new_stamp;
        wr_entry.expiry       = new_exp;
        wr_entry.payload      = pay_reg;
    end

    // owner, stale and valid bookkeeping
    always_comb begin
        valid_next   = valid_reg;
        own_has_next = own_has_reg;
        own_idx_next = own_idx_reg;
        stale_next   = stale_reg;
        if (cmd.accept && s_tuser == REQ_CLEAR) begin
            valid_next = '0;
            stale_next = 2'b11;
        end
        if (pv_live) begin
            if (type_reg == REQ_TICK && expired) begin
                valid_next[paddr] = 1'b0;
            end
            if (type_reg == REQ_RELEASE && hit && mask_reg[cmd.scan_dom]) begin
                valid_next[paddr] = 1'b0;
            end
        end
        if (do_write) begin
            valid_next[waddr] = 1'b1;
            if (own_has_reg[dom_reg] && own_idx_reg[dom_reg] == cslot) begin
                stale_next[dom_reg] = 1'b1;
            end
        end
        if (cmd.load_win) begin
            own_has_next[cmd.scan_dom] = win_found_reg;
            own_idx_next[cmd.scan_dom] = win_found_reg ? win_idx_reg : '0;
            stale_next[cmd.scan_dom]   = 1'b0;
        end
    end

    always_comb begin
        if (win_found_reg) begin
            changed = !(own_has_reg[cmd.scan_dom]
                        && own_idx_reg[cmd.scan_dom] == win_idx_reg)
                      || stale_reg[cmd.scan_dom];
        end else begin
            changed = own_has_reg[cmd.scan_dom] || stale_reg[cmd.scan_dom];
        end
        diff = win_exp_reg - time_reg;
        if (win_exp_reg > time_reg) begin
            rem = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
        end else begin
            rem = 32'd0;
        end
        if (type_reg == REQ_UPDATE && !match_found_reg) begin
            sts_v = STS_NOT_FOUND;
        end else if (type_reg > REQ_CLEAR) begin
            sts_v = STS_INVALID;
        end else begin
            sts_v = STS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            own_has_reg    <= '0;
            own_idx_reg[0] <= '0;
            own_idx_reg[1] <= '0;
            stale_reg      <= '0;
            time_reg       <= '0;
            stamp_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            own_has_reg <= own_has_next;
            own_idx_reg <= own_idx_next;
            stale_reg   <= stale_next;
            if (cmd.accept && s_tuser == REQ_TICK) begin
                time_reg <= time_reg + {48'd0, s_tdata[98:83]};
            end
            if (do_write) begin
                stamp_reg <= new_stamp;
            end
            if (cmd.load_one || cmd.load_win) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.scan_clr) begin
                cnt_reg <= '0;
                pv_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                if (cnt_reg < CNT_W'(SLOTS)) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    pv_reg  <= 1'b1;
                end else begin
                    pv_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            type_reg  <= s_tuser;
            dom_reg   <= s_tdata[0];
            mask_reg  <= s_tdata[2:1];
            src_reg   <= s_tdata[10:3];
            pri_reg   <= s_tdata[18:11];
            lease_reg <= s_tdata[50:19];
            pay_reg   <= s_tdata[82:51];
        end
        if (cmd.scan_step) begin
            pslot_reg <= cnt_reg[SLOT_W-1:0];
        end
        if (cmd.scan_clr) begin
            match_found_reg <= 1'b0;
            win_found_reg   <= 1'b0;
        end else if (pv_live) begin
            if (hit && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= pslot_reg;
            end
            if (pslot_reg == '0 || rd_entry.stamp < oldest_stamp_reg) begin
                oldest_idx_reg   <= pslot_reg;
                oldest_stamp_reg <= rd_entry.stamp;
            end
            if (live && better) begin
                win_found_reg <= 1'b1;
                win_idx_reg   <= pslot_reg;
                win_src_reg   <= rd_entry.source;
                win_pri_reg   <= rd_entry.priority_val;
                win_pay_reg   <= rd_entry.payload;
                win_exp_reg   <= rd_entry.expiry;
                win_stamp_reg <= rd_entry.stamp;
            end
        end
        if (cmd.load_one) begin
            out_sts_reg  <= sts_v;
            out_dom_reg  <= (type_reg == REQ_CLAIM || type_reg == REQ_UPDATE) ? dom_reg : 1'b0;
            out_wv_reg   <= 1'b0;
            out_chg_reg  <= 1'b0;
            out_src_reg  <= '0;
            out_pri_reg  <= '0;
            out_pay_reg  <= '0;
            out_rem_reg  <= '0;
            out_last_reg <= 1'b1;
        end else if (cmd.load_win) begin
            out_sts_reg  <= STS_OK;
            out_dom_reg  <= cmd.scan_dom;
            out_wv_reg   <= win_found_reg;
            out_chg_reg  <= changed;
            out_src_reg  <= win_found_reg ? win_src_reg : 8'd0;
            out_pri_reg  <= win_found_reg ? win_pri_reg : 8'd0;
            out_pay_reg  <= win_found_reg ? win_pay_reg : 32'd0;
            out_rem_reg  <= win_found_reg ? rem : 32'd0;
            out_last_reg <= cmd.scan_dom;
        end
    end

    assign stat.kind      = type_reg;
    assign stat.dom       = dom_reg;
    assign stat.scan_done = cmd.scan_step && (cnt_reg == CNT_W'(SLOTS));
    assign stat.out_busy  = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_sts_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_rem_reg, out_pay_reg, out_pri_reg, out_src_reg,
                       out_chg_reg, out_wv_reg, out_dom_reg};

endmodule
